// ----- src/ekdc_pkg.sv -----
// Shared constants for the escape key decoder with cursor tracking.
// Key kind codes, parser phases, terminal character codes and field widths.
// No dependencies.
package ekdc_pkg;

	localparam int COORD_WIDTH = 10;

	localparam int CFG_W    = 11;
	localparam int APB_DW   = 32;
	localparam int APB_AW   = 3;
	localparam int BYTE_W   = 8;
	localparam int KIND_W   = 3;
	localparam int CURSOR_W = 10;

	// Register indexes (paddr[2])
	localparam logic REG_SCREEN_ROWS = 1'b0;
	localparam logic REG_SCREEN_COLS = 1'b1;

	localparam logic [CFG_W-1:0] SCREEN_ROWS_RST = 11'd24;
	localparam logic [CFG_W-1:0] SCREEN_COLS_RST = 11'd80;

	// Parser phases
	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_ESC   = 2'd1;
	localparam logic [1:0] PH_SEQ   = 2'd2;
	localparam logic [1:0] PH_DIGIT = 2'd3;

	// Key kinds
	localparam logic [KIND_W-1:0] K_PLAIN = 3'd0;
	localparam logic [KIND_W-1:0] K_PGUP  = 3'd1;
	localparam logic [KIND_W-1:0] K_PGDN  = 3'd2;
	localparam logic [KIND_W-1:0] K_HOME  = 3'd3;
	localparam logic [KIND_W-1:0] K_END   = 3'd4;
	localparam logic [KIND_W-1:0] K_DEL   = 3'd5;
	localparam logic [KIND_W-1:0] K_ESC   = 3'd6;

	// Character codes
	localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
	localparam logic [BYTE_W-1:0] CH_ESC   = 8'h1B;
	localparam logic [BYTE_W-1:0] CH_LBRK  = 8'h5B;
	localparam logic [BYTE_W-1:0] CH_O     = 8'h4F;
	localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7E;
	localparam logic [BYTE_W-1:0] CH_Q     = 8'h71;
	localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
	localparam logic [BYTE_W-1:0] CH_1     = 8'h31;
	localparam logic [BYTE_W-1:0] CH_3     = 8'h33;
	localparam logic [BYTE_W-1:0] CH_4     = 8'h34;
	localparam logic [BYTE_W-1:0] CH_5     = 8'h35;
	localparam logic [BYTE_W-1:0] CH_6     = 8'h36;
	localparam logic [BYTE_W-1:0] CH_7     = 8'h37;
	localparam logic [BYTE_W-1:0] CH_8     = 8'h38;
	localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
	localparam logic [BYTE_W-1:0] CH_UA    = 8'h41;
	localparam logic [BYTE_W-1:0] CH_UB    = 8'h42;
	localparam logic [BYTE_W-1:0] CH_UC    = 8'h43;
	localparam logic [BYTE_W-1:0] CH_UD    = 8'h44;
	localparam logic [BYTE_W-1:0] CH_UF    = 8'h46;
	localparam logic [BYTE_W-1:0] CH_UH    = 8'h48;
	localparam logic [BYTE_W-1:0] CH_H     = 8'h68;
	localparam logic [BYTE_W-1:0] CH_J     = 8'h6A;
	localparam logic [BYTE_W-1:0] CH_K     = 8'h6B;
	localparam logic [BYTE_W-1:0] CH_L     = 8'h6C;

endpackage

// ----- src/escape_key_decoder_cursor_core.sv -----
// Escape key decoder with cursor tracking: top level.
// Decodes terminal bytes into keys and moves a cursor within the screen size.
// Depends on ekdc_pkg.
//
// channel  | dir | handshake          | payload
// s_*      | in  | s_tvalid/s_tready  | tdata: in_byte; tuser: no_byte
// m_*      | out | m_tvalid/m_tready  | tdata: key_byte, cursor_col, cursor_row;
//          |     |                    | tuser: key_kind, quit
// apb      | in  | psel/penable/pready| screen_rows @0x0, screen_cols @0x4
//
// One byte is taken every cycle while the result register is not stalled; an accepted
// byte goes into the input register, and its result is then loaded into the result register.
// The decode and cursor update sit between the input register and the result register.
// A stalled result register holds the input register; the input side then stops.
// arst_n clears the parser and the cursor and sets the screen size to 24 rows, 80 columns.
module escape_key_decoder_cursor_core #(
	parameter int COORD_WIDTH = ekdc_pkg::COORD_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [ekdc_pkg::BYTE_W-1:0]    s_tdata,  // [7:0] in_byte
	input  logic                           s_tuser,  // [0] no_byte
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [31:0]                    m_tdata,  // [7:0] key_byte, [17:8] cursor_col,
	                                                 // [27:18] cursor_row, [31:28] zero
	output logic [3:0]                     m_tuser,  // [2:0] key_kind, [3] quit_request
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ekdc_pkg::APB_AW-1:0]    paddr,
	input  logic [ekdc_pkg::APB_DW-1:0]    pwdata,
	output logic [ekdc_pkg::APB_DW-1:0]    prdata,
	output logic                           pready
);

	localparam int CW = COORD_WIDTH;
	localparam int EW = (CW > ekdc_pkg::CFG_W) ? CW : ekdc_pkg::CFG_W;

	// configuration
	logic [ekdc_pkg::CFG_W-1:0] screen_rows_q, screen_cols_q;
	logic                       cfg_wr;

	// input register
	logic                        valid_s1;
	logic [ekdc_pkg::BYTE_W-1:0] byte_s1;
	logic                        none_s1;
	logic                        advance;

	// parser and cursor state
	logic [1:0]                  phase_q, phase_d;
	logic [ekdc_pkg::BYTE_W-1:0] first_q, first_d;
	logic [ekdc_pkg::BYTE_W-1:0] digit_q, digit_d;
	logic [CW-1:0]               col_q, col_d, row_q, row_d;
	logic [CW-1:0]               last_col, last_row;

	// decode result
	logic                        res;
	logic [ekdc_pkg::KIND_W-1:0] kind;
	logic [ekdc_pkg::BYTE_W-1:0] kbyte;

	// result register
	logic                        m_valid_q;
	logic [ekdc_pkg::KIND_W-1:0] kind_q;
	logic [ekdc_pkg::BYTE_W-1:0] kbyte_q;
	logic [ekdc_pkg::CURSOR_W-1:0] col_out_q, row_out_q;
	logic                        quit_q;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_comb begin
		prdata = '0;
		if (paddr[2] == ekdc_pkg::REG_SCREEN_COLS) begin
			prdata[ekdc_pkg::CFG_W-1:0] = screen_cols_q;
		end else begin
			prdata[ekdc_pkg::CFG_W-1:0] = screen_rows_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_rows_q <= ekdc_pkg::SCREEN_ROWS_RST;
			screen_cols_q <= ekdc_pkg::SCREEN_COLS_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == ekdc_pkg::REG_SCREEN_COLS) begin
				screen_cols_q <= pwdata[ekdc_pkg::CFG_W-1:0];
			end else begin
				screen_rows_q <= pwdata[ekdc_pkg::CFG_W-1:0];
			end
		end
	end

	// Edge positions wrap to all ones for a zero screen size.
	assign last_row = CW'(EW'(screen_rows_q) - EW'(1));
	assign last_col = CW'(EW'(screen_cols_q) - EW'(1));

	assign advance  = valid_s1 & (~m_valid_q | m_tready);
	assign s_tready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			none_s1 <= s_tuser;
		end
	end

	always_comb begin
		phase_d = phase_q;
		first_d = first_q;
		digit_d = digit_q;
		col_d   = col_q;
		row_d   = row_q;
		res     = 1'b0;
		kind    = ekdc_pkg::K_PLAIN;
		kbyte   = ekdc_pkg::CH_NUL;

		if (none_s1) begin
			// timeout closes an open sequence as escape
			if (phase_q != ekdc_pkg::PH_IDLE) begin
				res     = 1'b1;
				kind    = ekdc_pkg::K_ESC;
				phase_d = ekdc_pkg::PH_IDLE;
			end
		end else begin
			case (phase_q)
				ekdc_pkg::PH_IDLE: begin
					if (byte_s1 == ekdc_pkg::CH_ESC) begin
						phase_d = ekdc_pkg::PH_ESC;
					end else begin
						res   = 1'b1;
						kbyte = byte_s1;
					end
				end
				ekdc_pkg::PH_ESC: begin
					first_d = byte_s1;
					phase_d = ekdc_pkg::PH_SEQ;
				end
				ekdc_pkg::PH_SEQ: begin
					if (first_q == ekdc_pkg::CH_LBRK &&
					    byte_s1 inside {[ekdc_pkg::CH_0:ekdc_pkg::CH_9]}) begin
						digit_d = byte_s1;
						phase_d = ekdc_pkg::PH_DIGIT;
					end else begin
						res     = 1'b1;
						phase_d = ekdc_pkg::PH_IDLE;
						kind    = ekdc_pkg::K_ESC;
						if (first_q == ekdc_pkg::CH_LBRK) begin
							case (byte_s1)
								ekdc_pkg::CH_UA: begin
									kind  = ekdc_pkg::K_PLAIN;
									kbyte = ekdc_pkg::CH_K;
								end
								ekdc_pkg::CH_UB: begin
									kind  = ekdc_pkg::K_PLAIN;
									kbyte = ekdc_pkg::CH_J;
								end
								ekdc_pkg::CH_UC: begin
									kind  = ekdc_pkg::K_PLAIN;
									kbyte = ekdc_pkg::CH_L;
								end
								ekdc_pkg::CH_UD: begin
									kind  = ekdc_pkg::K_PLAIN;
									kbyte = ekdc_pkg::CH_H;
								end
								ekdc_pkg::CH_UH: kind = ekdc_pkg::K_HOME;
								ekdc_pkg::CH_UF: kind = ekdc_pkg::K_END;
								default:         kind = ekdc_pkg::K_ESC;
							endcase
						end else if (first_q == ekdc_pkg::CH_O) begin
							if (byte_s1 == ekdc_pkg::CH_UH) begin
								kind = ekdc_pkg::K_HOME;
							end else if (byte_s1 == ekdc_pkg::CH_UF) begin
								kind = ekdc_pkg::K_END;
							end
						end
					end
				end
				default: begin
					res     = 1'b1;
					phase_d = ekdc_pkg::PH_IDLE;
					kind    = ekdc_pkg::K_ESC;
					if (byte_s1 == ekdc_pkg::CH_TILDE) begin
						case (digit_q)
							ekdc_pkg::CH_1: kind = ekdc_pkg::K_HOME;
							ekdc_pkg::CH_3: kind = ekdc_pkg::K_DEL;
							ekdc_pkg::CH_4: kind = ekdc_pkg::K_END;
							ekdc_pkg::CH_5: kind = ekdc_pkg::K_PGUP;
							ekdc_pkg::CH_6: kind = ekdc_pkg::K_PGDN;
							ekdc_pkg::CH_7: kind = ekdc_pkg::K_HOME;
							ekdc_pkg::CH_8: kind = ekdc_pkg::K_END;
							default:        kind = ekdc_pkg::K_ESC;
						endcase
					end
				end
			endcase
		end

		if (kind == ekdc_pkg::K_ESC) begin
			kbyte = ekdc_pkg::CH_ESC;
		end

		// cursor update: equality checks only, arithmetic wraps
		if (res) begin
			case (kind)
				ekdc_pkg::K_HOME: col_d = '0;
				ekdc_pkg::K_END:  col_d = last_col;
				ekdc_pkg::K_PGUP: row_d = '0;
				ekdc_pkg::K_PGDN: row_d = last_row;
				ekdc_pkg::K_PLAIN: begin
					if (kbyte == ekdc_pkg::CH_H && col_q != '0) begin
						col_d = col_q - CW'(1);
					end else if (kbyte == ekdc_pkg::CH_K && row_q != '0) begin
						row_d = row_q - CW'(1);
					end else if (kbyte == ekdc_pkg::CH_L && col_q != last_col) begin
						col_d = col_q + CW'(1);
					end else if (kbyte == ekdc_pkg::CH_J && row_q != last_row) begin
						row_d = row_q + CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ekdc_pkg::PH_IDLE;
			first_q <= '0;
			digit_q <= '0;
			col_q   <= '0;
			row_q   <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			first_q <= first_d;
			digit_q <= digit_d;
			col_q   <= col_d;
			row_q   <= row_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= res;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			kind_q    <= kind;
			kbyte_q   <= kbyte;
			col_out_q <= ekdc_pkg::CURSOR_W'(col_d);
			row_out_q <= ekdc_pkg::CURSOR_W'(row_d);
			quit_q    <= (kind == ekdc_pkg::K_PLAIN) && (kbyte == ekdc_pkg::CH_Q);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'b0000, row_out_q, col_out_q, kbyte_q};
	assign m_tuser  = {quit_q, kind_q};

	// quit only for a plain q
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!m_tuser[3] || (m_tuser[2:0] == ekdc_pkg::K_PLAIN &&
		                              m_tdata[7:0] == ekdc_pkg::CH_Q)))
		else $error("quit raised for a key other than plain q");

	// escape keys always carry the escape character
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[2:0] == ekdc_pkg::K_ESC) |->
			(m_tdata[7:0] == ekdc_pkg::CH_ESC))
		else $error("escape key without escape character");

	// a timeout always leaves the parser idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && none_s1) |=> (phase_q == ekdc_pkg::PH_IDLE))
		else $error("parser not idle after timeout");

	// a timeout while idle gives no result and leaves the cursor alone
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && none_s1 && phase_q == ekdc_pkg::PH_IDLE) |=>
			(!m_valid_q && $stable(col_q) && $stable(row_q)))
		else $error("idle timeout produced a result or moved the cursor");

endmodule

// ----- tb/escape_key_decoder_cursor_core_test.sv -----
// Self-checking bench for escape_key_decoder_cursor_core: streams terminal bytes and
// timeouts in, predicts each key and cursor position, checks every result.
// Depends on ekdc_pkg and the core; needs no files or arguments.
module escape_key_decoder_cursor_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT = 400000;

	typedef struct packed {
		logic [ekdc_pkg::KIND_W-1:0]   kind;
		logic [ekdc_pkg::BYTE_W-1:0]   key;
		logic [ekdc_pkg::CURSOR_W-1:0] col;
		logic [ekdc_pkg::CURSOR_W-1:0] row;
		logic                          quit;
	} key_event_t;

	class key_scoreboard;
		logic [1:0]                    phase;
		logic [ekdc_pkg::BYTE_W-1:0]   lead_byte;
		logic [ekdc_pkg::BYTE_W-1:0]   digit_byte;
		logic [ekdc_pkg::CURSOR_W-1:0] col;
		logic [ekdc_pkg::CURSOR_W-1:0] row;
		logic [ekdc_pkg::CFG_W-1:0]    rows;
		logic [ekdc_pkg::CFG_W-1:0]    cols;
		key_event_t                    awaited[$];
		int unsigned                   mismatches;
		int unsigned                   keys_checked;

		function new();
			phase = ekdc_pkg::PH_IDLE;
			lead_byte = '0;
			digit_byte = '0;
			col = '0;
			row = '0;
			rows = ekdc_pkg::SCREEN_ROWS_RST;
			cols = ekdc_pkg::SCREEN_COLS_RST;
			mismatches = 0;
			keys_checked = 0;
		endfunction

		function void flag(string msg);
			if (mismatches < 10) $display("MISMATCH: %s", msg);
			mismatches++;
		endfunction

		function void set_screen(logic idx, logic [ekdc_pkg::CFG_W-1:0] v);
			if (idx == ekdc_pkg::REG_SCREEN_ROWS) rows = v;
			else cols = v;
		endfunction

		function logic [ekdc_pkg::KIND_W-1:0] tilde_kind(logic [ekdc_pkg::BYTE_W-1:0] d);
			case (d)
				ekdc_pkg::CH_1, ekdc_pkg::CH_7: return ekdc_pkg::K_HOME;
				ekdc_pkg::CH_3:                 return ekdc_pkg::K_DEL;
				ekdc_pkg::CH_4, ekdc_pkg::CH_8: return ekdc_pkg::K_END;
				ekdc_pkg::CH_5:                 return ekdc_pkg::K_PGUP;
				ekdc_pkg::CH_6:                 return ekdc_pkg::K_PGDN;
				default:                        return ekdc_pkg::K_ESC;
			endcase
		endfunction

		function logic [ekdc_pkg::KIND_W-1:0] pair_kind(logic [ekdc_pkg::BYTE_W-1:0] lead,
				logic [ekdc_pkg::BYTE_W-1:0] last, output logic [ekdc_pkg::BYTE_W-1:0] ch);
			ch = ekdc_pkg::CH_NUL;
			if (lead == ekdc_pkg::CH_LBRK) begin
				case (last)
					ekdc_pkg::CH_UA: begin ch = ekdc_pkg::CH_K; return ekdc_pkg::K_PLAIN; end
					ekdc_pkg::CH_UB: begin ch = ekdc_pkg::CH_J; return ekdc_pkg::K_PLAIN; end
					ekdc_pkg::CH_UC: begin ch = ekdc_pkg::CH_L; return ekdc_pkg::K_PLAIN; end
					ekdc_pkg::CH_UD: begin ch = ekdc_pkg::CH_H; return ekdc_pkg::K_PLAIN; end
					ekdc_pkg::CH_UH: return ekdc_pkg::K_HOME;
					ekdc_pkg::CH_UF: return ekdc_pkg::K_END;
					default: return ekdc_pkg::K_ESC;
				endcase
			end
			if (lead == ekdc_pkg::CH_O && last == ekdc_pkg::CH_UH) return ekdc_pkg::K_HOME;
			if (lead == ekdc_pkg::CH_O && last == ekdc_pkg::CH_UF) return ekdc_pkg::K_END;
			return ekdc_pkg::K_ESC;
		endfunction

		// Edge checks are equality only, so a cursor past the edge keeps going and wraps
		function void move_cursor(logic [ekdc_pkg::KIND_W-1:0] kind,
				logic [ekdc_pkg::BYTE_W-1:0] ch);
			logic [ekdc_pkg::CURSOR_W-1:0] last_row;
			logic [ekdc_pkg::CURSOR_W-1:0] last_col;
			last_row = ekdc_pkg::CURSOR_W'(rows - 1);
			last_col = ekdc_pkg::CURSOR_W'(cols - 1);
			case (kind)
				ekdc_pkg::K_HOME: col = '0;
				ekdc_pkg::K_END:  col = last_col;
				ekdc_pkg::K_PGUP: row = '0;
				ekdc_pkg::K_PGDN: row = last_row;
				ekdc_pkg::K_PLAIN: begin
					if (ch == ekdc_pkg::CH_H && col != 0) col = col - 1'b1;
					else if (ch == ekdc_pkg::CH_K && row != 0) row = row - 1'b1;
					else if (ch == ekdc_pkg::CH_L && col != last_col) col = col + 1'b1;
					else if (ch == ekdc_pkg::CH_J && row != last_row) row = row + 1'b1;
				end
				default: ;
			endcase
		endfunction

		// Returns 0 only for a timeout while idle, which the block ignores
		function bit note_input(logic [ekdc_pkg::BYTE_W-1:0] b, logic nob);
			logic [ekdc_pkg::KIND_W-1:0] kind;
			logic [ekdc_pkg::BYTE_W-1:0] ch;
			key_event_t                  ev;
			kind = ekdc_pkg::K_PLAIN;
			ch = ekdc_pkg::CH_NUL;
			if (nob) begin
				if (phase == ekdc_pkg::PH_IDLE) return 0;
				kind = ekdc_pkg::K_ESC;
				phase = ekdc_pkg::PH_IDLE;
			end else begin
				case (phase)
					ekdc_pkg::PH_IDLE: begin
						if (b == ekdc_pkg::CH_ESC) begin
							phase = ekdc_pkg::PH_ESC;
							return 1;
						end
						ch = b;
					end
					ekdc_pkg::PH_ESC: begin
						lead_byte = b;
						phase = ekdc_pkg::PH_SEQ;
						return 1;
					end
					ekdc_pkg::PH_SEQ: begin
						if (lead_byte == ekdc_pkg::CH_LBRK && b >= ekdc_pkg::CH_0 &&
						    b <= ekdc_pkg::CH_9) begin
							digit_byte = b;
							phase = ekdc_pkg::PH_DIGIT;
							return 1;
						end
						kind = pair_kind(lead_byte, b, ch);
						phase = ekdc_pkg::PH_IDLE;
					end
					default: begin
						kind = (b == ekdc_pkg::CH_TILDE) ? tilde_kind(digit_byte)
						                                 : ekdc_pkg::K_ESC;
						phase = ekdc_pkg::PH_IDLE;
					end
				endcase
			end
			if (kind == ekdc_pkg::K_ESC) ch = ekdc_pkg::CH_ESC;
			move_cursor(kind, ch);
			ev.kind = kind;
			ev.key = ch;
			ev.col = col;
			ev.row = row;
			ev.quit = (kind == ekdc_pkg::K_PLAIN && ch == ekdc_pkg::CH_Q);
			awaited.push_back(ev);
			return 1;
		endfunction

		function void check_result(key_event_t got);
			key_event_t want;
			if (awaited.size() == 0) begin
				flag($sformatf("unexpected key kind=%0d byte=%02h col=%0d row=%0d quit=%0b",
					got.kind, got.key, got.col, got.row, got.quit));
				return;
			end
			want = awaited.pop_front();
			keys_checked++;
			if (got !== want)
				flag($sformatf({"key %0d: expected kind=%0d byte=%02h col=%0d row=%0d quit=%0b,",
					" got kind=%0d byte=%02h col=%0d row=%0d quit=%0b"}, keys_checked,
					want.kind, want.key, want.col, want.row, want.quit,
					got.kind, got.key, got.col, got.row, got.quit));
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [ekdc_pkg::BYTE_W-1:0]   s_tdata;  // [7:0] in_byte
	logic                          s_tuser;  // [0] no_byte
	logic                          m_tvalid;
	logic                          m_tready;
	logic [31:0]                   m_tdata;  // [7:0] key_byte, [17:8] cursor_col, [27:18] cursor_row
	logic [3:0]                    m_tuser;  // [2:0] key_kind, [3] quit_request
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [ekdc_pkg::APB_AW-1:0]   paddr;
	logic [ekdc_pkg::APB_DW-1:0]   pwdata;
	logic [ekdc_pkg::APB_DW-1:0]   prdata;
	logic                          pready;

	key_scoreboard sb = new();
	int unsigned   live_bytes = 0;
	int unsigned   settings_used = 1;
	int unsigned   cycles = 0;
	bit            src_steady = 1'b0;
	bit            sink_steady = 1'b0;

	escape_key_decoder_cursor_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("timeout after %0d cycles, %0d keys outstanding", cycles, sb.awaited.size());
			$display("tb: failure");
			$finish;
		end
	end

	// Entered and left at a falling edge
	task automatic send_byte(input logic [ekdc_pkg::BYTE_W-1:0] b, input logic nob);
		int gap;
		if ($urandom_range(0, 39) == 0) src_steady = !src_steady;
		gap = src_steady ? 0 : $urandom_range(0, 13);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= nob;
		do @(posedge clk); while (!s_tready);
		if (sb.note_input(b, nob)) live_bytes++;
		@(negedge clk);
	endtask

	task automatic send_text(input string txt);
		foreach (txt[i]) send_byte(txt[i], 1'b0);
	endtask

	task automatic send_timeout();
		send_byte(ekdc_pkg::BYTE_W'($urandom_range(0, 255)), 1'b1);
	endtask

	// Write the register, then read it back
	task automatic configure(input logic idx, input logic [ekdc_pkg::CFG_W-1:0] v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= ekdc_pkg::APB_DW'(v);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[ekdc_pkg::CFG_W-1:0] !== v)
			sb.flag($sformatf("register %0d read %0d, wrote %0d", idx,
				prdata[ekdc_pkg::CFG_W-1:0], v));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		sb.set_screen(idx, v);
	endtask

	// Drain, let any byte still in flight settle, then resize
	task automatic set_screen(input logic [ekdc_pkg::CFG_W-1:0] rows,
			input logic [ekdc_pkg::CFG_W-1:0] cols);
		s_tvalid <= 1'b0;
		while (sb.awaited.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		configure(ekdc_pkg::REG_SCREEN_ROWS, rows);
		configure(ekdc_pkg::REG_SCREEN_COLS, cols);
		settings_used++;
	endtask

	task automatic send_sequence();
		logic [ekdc_pkg::BYTE_W-1:0] arrows [4] = '{ekdc_pkg::CH_UA, ekdc_pkg::CH_UB,
			ekdc_pkg::CH_UC, ekdc_pkg::CH_UD};
		send_byte(ekdc_pkg::CH_ESC, 1'b0);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				send_byte(ekdc_pkg::CH_LBRK, 1'b0);
				send_byte(arrows[$urandom_range(0, 3)], 1'b0);
			end
			4: begin
				send_byte(ekdc_pkg::CH_LBRK, 1'b0);
				send_byte(ekdc_pkg::CH_UH, 1'b0);
			end
			5: begin
				send_byte(ekdc_pkg::CH_LBRK, 1'b0);
				send_byte(ekdc_pkg::CH_UF, 1'b0);
			end
			6: begin
				send_byte(ekdc_pkg::CH_O, 1'b0);
				send_byte($urandom_range(0, 1) ? ekdc_pkg::CH_UH : ekdc_pkg::CH_UF, 1'b0);
			end
			default: begin
				send_byte(ekdc_pkg::CH_LBRK, 1'b0);
				send_byte(ekdc_pkg::CH_0 + ekdc_pkg::BYTE_W'($urandom_range(0, 9)), 1'b0);
				send_byte(ekdc_pkg::CH_TILDE, 1'b0);
			end
		endcase
	endtask

	// Cut short by a timeout or an unexpected byte
	task automatic send_broken();
		send_byte(ekdc_pkg::CH_ESC, 1'b0);
		case ($urandom_range(0, 4))
			0: send_timeout();
			1: begin
				send_byte(ekdc_pkg::BYTE_W'($urandom_range(0, 255)), 1'b0);
				send_byte(ekdc_pkg::BYTE_W'($urandom_range(0, 255)), 1'b0);
			end
			2: begin
				send_byte(ekdc_pkg::CH_LBRK, 1'b0);
				send_byte(ekdc_pkg::CH_0 + ekdc_pkg::BYTE_W'($urandom_range(0, 9)), 1'b0);
				if ($urandom_range(0, 1)) send_timeout();
				else send_byte(ekdc_pkg::BYTE_W'($urandom_range(0, 255)), 1'b0);
			end
			3: begin
				send_byte(ekdc_pkg::CH_O, 1'b0);
				if ($urandom_range(0, 1)) send_timeout();
				else send_byte(ekdc_pkg::BYTE_W'($urandom_range(0, 255)), 1'b0);
			end
			default: begin
				send_byte(ekdc_pkg::CH_LBRK, 1'b0);
				send_timeout();
			end
		endcase
	endtask

	task automatic random_run(input int unsigned n);
		logic [ekdc_pkg::BYTE_W-1:0] moves [5] = '{ekdc_pkg::CH_H, ekdc_pkg::CH_J,
			ekdc_pkg::CH_K, ekdc_pkg::CH_L, ekdc_pkg::CH_Q};
		int unsigned stop_at;
		int pick;
		stop_at = live_bytes + n;
		while (live_bytes < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) send_sequence();
			else if (pick < 62) send_byte(moves[$urandom_range(0, 4)], 1'b0);
			else if (pick < 74) send_byte(ekdc_pkg::BYTE_W'($urandom_range(0, 255)), 1'b0);
			else if (pick < 88) send_broken();
			else send_timeout();
		end
	endtask

	initial begin
		int stall;
		m_tready = 1'b0;
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0) sink_steady = !sink_steady;
			stall = sink_steady ? 0 : $urandom_range(0, 13);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_result({m_tuser[2:0], m_tdata[7:0], m_tdata[17:8], m_tdata[27:18],
				m_tuser[3]});
			@(negedge clk);
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Plain extremes, quit, idle timeout, then arrow, SS3 end, tilde, escape timeout and unknown sequence at reset size
		send_byte(ekdc_pkg::CH_Q, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_timeout();
		send_text("\033[A");
		send_text("\033OF");
		send_text("\033[5~");
		send_byte(ekdc_pkg::CH_ESC, 1'b0);
		send_timeout();
		send_text("\033[Z");

		// Park the cursor at the far corner, then shrink the screen under it
		set_screen(11'd1024, 11'd1024);
		send_text("\033[F");
		send_text("\033[6~");
		set_screen(11'd4, 11'd4);
		send_byte(ekdc_pkg::CH_L, 1'b0);
		send_byte(ekdc_pkg::CH_J, 1'b0);
		random_run(110);

		set_screen(11'd1024, 11'd1024);
		random_run(110);
		set_screen(11'd0, 11'd0);
		random_run(110);
		set_screen(11'd1, 11'd1);
		random_run(160);
		set_screen(ekdc_pkg::CFG_W'($urandom_range(1, 40)),
			ekdc_pkg::CFG_W'($urandom_range(1, 40)));
		random_run(110);
		set_screen(11'd1024, ekdc_pkg::CFG_W'($urandom_range(1, 1024)));
		random_run(110);

		s_tvalid <= 1'b0;
		while (sb.awaited.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		$display("covered %0d bytes over %0d screen sizes, %0d keys checked in %0d cycles",
			live_bytes, settings_used, sb.keys_checked, cycles);
		$display("%0d mismatches", sb.mismatches);
		if (sb.mismatches == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end
endmodule

// ----- sim.f -----
src/ekdc_pkg.sv
src/escape_key_decoder_cursor_core.sv
tb/escape_key_decoder_cursor_core_test.sv
